// File: sv/lkv_pkg.sv
// lkv_pkg: shared types and constants of the linear key/value table
// used by lkv_cell, linear_key_value_table and lkv_checker; no dependencies
package lkv_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_GET = 2'd0,
    OP_PUT = 2'd1,
    OP_DEL = 2'd2,
    OP_CLR = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef logic signed [DATA_W-1:0] data_t;

  // command broadcast to every cell during the execute cycle
  typedef struct packed {
    logic             exec;
    op_t              op;
    data_t            key;
    data_t            value;
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
  } lkv_cmd_t;

endpackage

// File: sv/linear_key_value_table.sv
// linear_key_value_table: top level, a chain of lkv_cell slots plus control
// depends on lkv_pkg and lkv_cell
//
// usage:
//   a command word (in_operation, in_key, in_value) is taken at a rising edge
//   with start high and busy low. operations: get, put (overwrite or append),
//   delete (later pairs move down one slot) and clear.
//   busy is high for the one execute cycle that follows the accepting edge.
//   in that cycle every slot compares its key against the command key at
//   once; the hit slot index and read value come from or-trees over the
//   slots, and each slot updates itself from the command or from its upper
//   neighbor.
//   the result word appears in the cycle after the execute cycle with
//   out_valid high for exactly one cycle; the receiver cannot stall it.
//   a new command is not taken until the single execute cycle of the chain
//   is over, since accept needs busy low.
//   reset (rst_n low, synchronous) empties the table and drops any command
//   in flight; slot contents are not cleared, only the entry count.
module linear_key_value_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_operation,
  input  logic signed [31:0]            in_key,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  output logic signed [31:0]            out_read_value,
  output logic                          out_found,
  output logic                          out_full_refused,
  output logic [6:0]                    out_entry_total
);
  import lkv_pkg::*;

  state_t           state_r, state_nxt;
  op_t              op_r;
  data_t            key_r, value_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  data_t            out_read_value_r;
  logic             out_found_r, out_full_refused_r;
  logic [CNT_W-1:0] out_entry_total_r;

  logic             exec;
  logic             accept;
  lkv_cmd_t         cmd;
  logic             hit;
  logic [IDX_W-1:0] slot;
  data_t            hit_value;
  logic             refuse;

  data_t            cell_key   [CAPACITY];
  data_t            cell_value [CAPACITY];
  logic             cell_match [CAPACITY];

  // control state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    exec      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        busy      = 1'b1;
        exec      = 1'b1;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign accept = start && !busy;

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_operation);
      key_r   <= in_key;
      value_r <= in_value;
    end
  end

  // hit, slot index and read value from or-trees over the chain
  always_comb begin
    hit       = 1'b0;
    slot      = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | cell_match[i];
      slot      = slot | (cell_match[i] ? IDX_W'(i) : IDX_W'(0));
      hit_value = hit_value | (cell_match[i] ? cell_value[i] : data_t'(0));
    end
  end

  assign cmd.exec  = exec;
  assign cmd.op    = op_r;
  assign cmd.key   = key_r;
  assign cmd.value = value_r;
  assign cmd.hit   = hit;
  assign cmd.slot  = slot;
  assign cmd.count = count_r;

  // the chain of slots
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t up_key, up_value;
    if (g == CAPACITY - 1) begin : g_top
      assign up_key   = '0;
      assign up_value = '0;
    end else begin : g_mid
      assign up_key   = cell_key[g+1];
      assign up_value = cell_value[g+1];
    end
    lkv_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(g)),
      .cmd      (cmd),
      .up_key   (up_key),
      .up_value (up_value),
      .key_q    (cell_key[g]),
      .value_q  (cell_value[g]),
      .match    (cell_match[g])
    );
  end

  // entry count
  assign refuse = (op_r == OP_PUT) && !hit && (count_r == CNT_W'(CAPACITY));

  always_comb begin
    count_nxt = count_r;
    if (exec) begin
      case (op_r)
        OP_CLR: count_nxt = '0;
        OP_PUT: if (!hit && !refuse) count_nxt = count_r + CNT_W'(1);
        OP_DEL: if (hit) count_nxt = count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= exec;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (exec) begin
      out_read_value_r   <= (op_r == OP_GET && hit) ? hit_value : data_t'(0);
      out_found_r        <= (op_r != OP_CLR) && hit;
      out_full_refused_r <= refuse;
      out_entry_total_r  <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_read_value_r;
  assign out_found        = out_found_r;
  assign out_full_refused = out_full_refused_r;
  assign out_entry_total  = 7'(out_entry_total_r);

endmodule

// File: sv/lkv_cell.sv
// lkv_cell: one slot of the table, holding a key/value pair
// depends on lkv_pkg; passes its pair down to the lower neighbor on delete
module lkv_cell (
  input  logic                    clk,
  input  logic [lkv_pkg::IDX_W-1:0] cell_idx,
  input  lkv_pkg::lkv_cmd_t       cmd,
  input  lkv_pkg::data_t          up_key,
  input  lkv_pkg::data_t          up_value,
  output lkv_pkg::data_t          key_q,
  output lkv_pkg::data_t          value_q,
  output logic                    match
);
  import lkv_pkg::*;

  data_t            key_r, key_nxt;
  data_t            value_r, value_nxt;
  logic             occupied;
  logic [CNT_W-1:0] idx_ext;

  assign idx_ext  = CNT_W'(cell_idx);
  assign occupied = idx_ext < cmd.count;
  assign match    = occupied && (key_r == cmd.key);
  assign key_q    = key_r;
  assign value_q  = value_r;

  // slot update: overwrite, append at the tail, or shift down on delete
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (cmd.exec) begin
      case (cmd.op)
        OP_PUT: begin
          if (cmd.hit) begin
            if (match) value_nxt = cmd.value;
          end else if (idx_ext == cmd.count) begin
            key_nxt   = cmd.key;
            value_nxt = cmd.value;
          end
        end
        OP_DEL: begin
          if (cmd.hit && (cell_idx >= cmd.slot)) begin
            key_nxt   = up_key;
            value_nxt = up_value;
          end
        end
        default: ;
      endcase
    end
  end

  // pair storage
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

// File: sv/lkv_checker.sv
// lkv_checker: port-level assertions for linear_key_value_table
// depends on lkv_pkg; bound to the top level below
module lkv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_read_value,
  input logic               out_found,
  input logic               out_full_refused,
  input logic [6:0]         out_entry_total
);
  import lkv_pkg::*;

  // an accepted word yields a result through the execute state and the out_valid register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("missing result after accepted word");

  // the result strobe never overlaps the execute cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside its slot");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_total <= 7'(CAPACITY))
    else $error("entry count beyond capacity");

  // a refused put only happens on a full table with a new key
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_refused) |->
      (out_entry_total == 7'(CAPACITY)) && !out_found && (out_read_value == 0))
    else $error("bad refused put");

  // a nonzero read value needs a hit
  a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_value != 0) |-> out_found)
    else $error("read value without hit");

endmodule

bind linear_key_value_table lkv_checker u_lkv_checker (.*);
